>>> hdl/ots_pkg.sv
// Shared types and fixed-point constants for the octant triangle-to-sphere core.
// No dependencies; imported by every module of the block.
`default_nettype none

package ots_pkg;

  // Q1.15 fixed point
  localparam int FRAC  = 15;
  localparam int CW    = FRAC + 1;        // coordinate / component width
  localparam int IW    = FRAC + 2;        // unnormalised component width
  localparam int SQW   = 2 * IW;          // squared length
  localparam int RW    = IW;              // square root width
  localparam int QB    = FRAC + 1;        // quotient bits (result never above one)
  localparam int DW    = IW + FRAC + 1;   // dividend width
  localparam int LVL_W = 5;               // level count, up to fifteen

  localparam logic [CW-1:0] ONE  = CW'(1) << FRAC;
  localparam logic [CW-1:0] HALF = ONE >> 1;
  localparam logic [3:0]    LVL_RST = 4'd8;

  typedef logic [CW-1:0]    comp_t;
  typedef comp_t [2:0]      cvec_t;   // index 0 = x, 1 = y, 2 = z
  typedef logic [IW-1:0]    wide_t;
  typedef wide_t [2:0]      wvec_t;
  typedef cvec_t [2:0]      tri_t;    // corners c1, c2, c3 at index 0, 1, 2
  typedef logic [LVL_W-1:0] lvl_t;

  // sub-triangle picked at one level
  typedef enum logic [1:0] {
    SEL_C1,
    SEL_MID,
    SEL_C3,
    SEL_C2
  } sel_t;

  // per-level control travelling alongside the midpoint normalisers
  typedef struct packed {
    sel_t  sel;
    logic  act;
    comp_t x;
    comp_t y;
    lvl_t  lvls;
    cvec_t c1;
  } lvl_sb_t;

endpackage

`default_nettype wire

>>> hdl/octant_triangle_to_sphere_core.sv
// Throughput: one item per cycle while the output is not stalled; every
// level always occupies its 37 stages (17-step square root and 16-step
// divide in the midpoint normalisers).
// A stall at the output freezes the whole pipeline; the input is taken again
// once the output register is free. Synchronous active-low reset clears valid
// bits and loads eight levels; there is no clearing pass.
`default_nettype none

module octant_triangle_to_sphere_core #(
  parameter int MAX_LEVELS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_tri_x,
  input  logic [15:0] in_tri_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_vec_x,
  output logic [15:0] out_vec_y,
  output logic [15:0] out_vec_z,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import ots_pkg::*;

  localparam tri_t TRI_INIT = {
    {comp_t'(0), ONE, comp_t'(0)},
    {comp_t'(0), comp_t'(0), ONE},
    {ONE, comp_t'(0), comp_t'(0)}
  };
  localparam lvl_t MAXL = lvl_t'(MAX_LEVELS);

  logic       en;
  logic [3:0] lvl_cfg_r;
  lvl_t       lvl_cfg;
  logic       e_vld_r;
  comp_t      e_x_r, e_y_r;
  lvl_t       e_lvls_r;

  logic       ch_vld  [MAX_LEVELS+1];
  comp_t      ch_x    [MAX_LEVELS+1];
  comp_t      ch_y    [MAX_LEVELS+1];
  lvl_t       ch_lvls [MAX_LEVELS+1];
  tri_t       ch_c    [MAX_LEVELS+1];

  logic       ip_vld, ip_nz;
  wvec_t      ip_p;
  logic       fin_nz;
  cvec_t      fin_vec;

  // whole pipeline moves unless the output item is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // level count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_cfg_r <= LVL_RST;
    end else if (cfg_wr_en) begin
      lvl_cfg_r <= cfg_wr_data;
    end
  end

  assign lvl_cfg = lvl_t'(lvl_cfg_r);

  // entry stage: clamp coordinates and level count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_x_r    <= (in_tri_x > ONE) ? ONE : in_tri_x;
      e_y_r    <= (in_tri_y > ONE) ? ONE : in_tri_y;
      e_lvls_r <= (lvl_cfg > MAXL) ? MAXL : lvl_cfg;
    end
  end

  assign ch_vld[0]  = e_vld_r;
  assign ch_x[0]    = e_x_r;
  assign ch_y[0]    = e_y_r;
  assign ch_lvls[0] = e_lvls_r;
  assign ch_c[0]    = TRI_INIT;

  // subdivision levels
  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_lvl
    ots_level #(.LV(l)) u_level (
      .clk, .rst_n, .en,
      .in_vld(ch_vld[l]), .in_x(ch_x[l]), .in_y(ch_y[l]),
      .in_lvls(ch_lvls[l]), .in_c(ch_c[l]),
      .out_vld(ch_vld[l+1]), .out_x(ch_x[l+1]), .out_y(ch_y[l+1]),
      .out_lvls(ch_lvls[l+1]), .out_c(ch_c[l+1])
    );
  end

  // interpolate inside the final triangle
  ots_interp u_interp (
    .clk, .rst_n, .en,
    .in_vld(ch_vld[MAX_LEVELS]), .in_x(ch_x[MAX_LEVELS]), .in_y(ch_y[MAX_LEVELS]),
    .in_c(ch_c[MAX_LEVELS]),
    .out_vld(ip_vld), .out_p(ip_p), .out_nz(ip_nz)
  );

  // final normalise; its last stage is the output register
  ots_norm #(.SB_W(1)) u_final (
    .clk, .rst_n, .en,
    .in_vld(ip_vld), .in_vec(ip_p), .in_sb(ip_nz),
    .out_vld(out_valid), .out_vec(fin_vec), .out_sb(fin_nz)
  );

  assign out_vec_x = fin_vec[0];
  assign out_vec_y = fin_vec[1];
  assign out_vec_z = fin_vec[2];

`ifndef NO_ASSERTIONS
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vec_x <= ONE) && (out_vec_y <= ONE) && (out_vec_z <= ONE))
    else $error("result component above one");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fin_nz |-> (out_vec_x >= HALF) || (out_vec_y >= HALF) || (out_vec_z >= HALF))
    else $error("normalised result too short");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fin_nz |-> (out_vec_x == '0) && (out_vec_y == '0) && (out_vec_z == '0))
    else $error("zero vector did not give zero result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(e_vld_r) && $stable(e_x_r) && $stable(e_y_r))
    else $error("entry stage moved during stall");

  a_lvls: assert property (@(posedge clk) disable iff (!rst_n)
    ch_vld[MAX_LEVELS] |-> ch_lvls[MAX_LEVELS] <= MAXL)
    else $error("level count above maximum");
`endif

endmodule

`default_nettype wire

>>> hdl/ots_norm.sv
// Pipelined vector normaliser: squares, digit-by-digit square root, three
// restoring dividers. Depends on ots_pkg.
`default_nettype none

module ots_norm #(
  parameter int SB_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  ots_pkg::wvec_t      in_vec,
  input  logic [SB_W-1:0]     in_sb,
  output logic                out_vld,
  output ots_pkg::cvec_t      out_vec,
  output logic [SB_W-1:0]     out_sb
);
  import ots_pkg::*;

  localparam int RT0  = 2;          // first root step
  localparam int PREP = RT0 + RW;   // dividend set-up
  localparam int NS   = PREP + 1 + QB;

  logic [NS-1:0]   vld_r;
  logic [SB_W-1:0] sb_r [NS];
  wvec_t           vec_r [PREP];
  logic [SQW-1:0]  prod_r [3];
  logic [SQW-1:0]  sum_r;
  logic [SQW-1:0]  rv_r [RW];
  logic [SQW-1:0]  rr_r [RW];
  logic [RW-1:0]   root;
  logic [RW-1:0]   lenp_r;
  logic [DW-1:0]   num_r [3];
  logic [RW-1:0]   len_r [QB];
  logic [DW-1:0]   rem_r [QB][3];
  comp_t           q_r [QB][3];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  assign root = rr_r[RW-1][RW-1:0];

  // sideband, vector delay line, squares, sum, dividend set-up
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int s = 1; s < NS; s++) sb_r[s] <= sb_r[s-1];
      vec_r[0] <= in_vec;
      for (int s = 1; s < PREP; s++) vec_r[s] <= vec_r[s-1];
      for (int i = 0; i < 3; i++) prod_r[i] <= SQW'(in_vec[i]) * SQW'(in_vec[i]);
      sum_r  <= prod_r[0] + prod_r[1] + prod_r[2];
      lenp_r <= root;
      for (int i = 0; i < 3; i++)
        num_r[i] <= (DW'(vec_r[PREP-1][i]) << FRAC) + DW'(root[RW-1:1]);
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_root
    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (RW - 1 - k));
    logic [SQW-1:0] v_in, r_in, trial;
    if (k == 0) begin : g_first
      assign v_in = sum_r;
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = rv_r[k-1];
      assign r_in = rr_r[k-1];
    end
    assign trial = r_in + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_in >= trial) begin
          rv_r[k] <= v_in - trial;
          rr_r[k] <= (r_in >> 1) + BITV;
        end else begin
          rv_r[k] <= v_in;
          rr_r[k] <= r_in >> 1;
        end
      end
    end
  end

  // division by the length, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [RW-1:0] l_in;
    logic [DW-1:0] r_in [3];
    comp_t         q_in [3];
    logic [DW-1:0] dsh;
    if (j == 0) begin : g_first
      assign l_in = lenp_r;
      assign r_in = num_r;
      assign q_in = '{default: '0};
    end else begin : g_rest
      assign l_in = len_r[j-1];
      assign r_in = rem_r[j-1];
      assign q_in = q_r[j-1];
    end
    assign dsh = DW'(l_in) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j] <= l_in;
        for (int i = 0; i < 3; i++) begin
          if (r_in[i] >= dsh) begin
            rem_r[j][i] <= r_in[i] - dsh;
            q_r[j][i]   <= q_in[i] | (comp_t'(1) << SH);
          end else begin
            rem_r[j][i] <= r_in[i];
            q_r[j][i]   <= q_in[i];
          end
        end
      end
    end
  end

  // zero length gives a zero vector
  always_comb begin
    for (int i = 0; i < 3; i++)
      out_vec[i] = (len_r[QB-1] == '0) ? '0 : q_r[QB-1][i];
  end

  assign out_vld = vld_r[NS-1];
  assign out_sb  = sb_r[NS-1];

endmodule

`default_nettype wire

>>> hdl/ots_level.sv
// One subdivision level: sub-triangle choice, point rescale, three midpoint
// normalisers and corner selection. Depends on ots_pkg and ots_norm.
`default_nettype none

module ots_level #(
  parameter int LV = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  ots_pkg::comp_t in_x,
  input  ots_pkg::comp_t in_y,
  input  ots_pkg::lvl_t  in_lvls,
  input  ots_pkg::tri_t  in_c,
  output logic          out_vld,
  output ots_pkg::comp_t out_x,
  output ots_pkg::comp_t out_y,
  output ots_pkg::lvl_t  out_lvls,
  output ots_pkg::tri_t  out_c
);
  import ots_pkg::*;

  localparam logic [CW:0] ONE_X = (CW+1)'(ONE);

  sel_t        sel;
  logic        act;
  logic [CW:0] x2, y2, nx, ny;
  lvl_sb_t     sb_in, sb_out;
  wvec_t       s12, s23, s31;
  cvec_t       m12, m23, m31, c2_d, c3_d;
  logic        v0, v1, v2;
  logic        vld_r;
  comp_t       x_r, y_r;
  lvl_t        lvls_r;
  tri_t        c_r;

  assign act = in_lvls > lvl_t'(LV);
  assign x2  = {in_x, 1'b0};
  assign y2  = {in_y, 1'b0};

  // pick the sub-triangle
  always_comb begin
    priority if (in_x >= HALF) begin
      sel = SEL_C2;
    end else if (in_y >= HALF) begin
      sel = SEL_C3;
    end else if (({1'b0, in_x} + {1'b0, in_y}) < {1'b0, HALF}) begin
      sel = SEL_C1;
    end else begin
      sel = SEL_MID;
    end
  end

  // rescale the point into it
  always_comb begin
    unique case (sel)
      SEL_C1: begin
        nx = x2;
        ny = y2;
      end
      SEL_MID: begin
        nx = ONE_X - x2;
        ny = ONE_X - y2;
      end
      SEL_C3: begin
        nx = x2;
        ny = y2 - ONE_X;
      end
      default: begin
        nx = x2 - ONE_X;
        ny = y2;
      end
    endcase
  end

  always_comb begin
    sb_in.sel  = sel;
    sb_in.act  = act;
    sb_in.x    = !act ? in_x : ((nx > ONE_X) ? ONE : nx[CW-1:0]);
    sb_in.y    = !act ? in_y : ((ny > ONE_X) ? ONE : ny[CW-1:0]);
    sb_in.lvls = in_lvls;
    sb_in.c1   = in_c[0];
    for (int i = 0; i < 3; i++) begin
      s12[i] = IW'(in_c[0][i]) + IW'(in_c[1][i]);
      s23[i] = IW'(in_c[1][i]) + IW'(in_c[2][i]);
      s31[i] = IW'(in_c[2][i]) + IW'(in_c[0][i]);
    end
  end

  // edge midpoints; the old corners ride along as sideband
  ots_norm #(.SB_W($bits(lvl_sb_t))) u_m12 (
    .clk, .rst_n, .en,
    .in_vld(in_vld), .in_vec(s12), .in_sb(sb_in),
    .out_vld(v0), .out_vec(m12), .out_sb(sb_out)
  );

  ots_norm #(.SB_W($bits(cvec_t))) u_m23 (
    .clk, .rst_n, .en,
    .in_vld(in_vld), .in_vec(s23), .in_sb(in_c[1]),
    .out_vld(v1), .out_vec(m23), .out_sb(c2_d)
  );

  ots_norm #(.SB_W($bits(cvec_t))) u_m31 (
    .clk, .rst_n, .en,
    .in_vld(in_vld), .in_vec(s31), .in_sb(in_c[2]),
    .out_vld(v2), .out_vec(m31), .out_sb(c3_d)
  );

  // level output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= v0 & v1 & v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= sb_out.x;
      y_r    <= sb_out.y;
      lvls_r <= sb_out.lvls;
      if (!sb_out.act) begin
        c_r[0] <= sb_out.c1;
        c_r[1] <= c2_d;
        c_r[2] <= c3_d;
      end else begin
        unique case (sb_out.sel)
          SEL_C1: begin
            c_r[0] <= sb_out.c1;
            c_r[1] <= m12;
            c_r[2] <= m31;
          end
          SEL_MID: begin
            c_r[0] <= m23;
            c_r[1] <= m31;
            c_r[2] <= m12;
          end
          SEL_C3: begin
            c_r[0] <= m31;
            c_r[1] <= m23;
            c_r[2] <= c3_d;
          end
          default: begin
            c_r[0] <= m12;
            c_r[1] <= c2_d;
            c_r[2] <= m23;
          end
        endcase
      end
    end
  end

  assign out_vld  = vld_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_lvls = lvls_r;
  assign out_c    = c_r;

endmodule

`default_nettype wire

>>> hdl/ots_interp.sv
// Linear interpolation inside the final triangle, three stages:
// products, sums, round and clip. Depends on ots_pkg.
`default_nettype none

module ots_interp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  ots_pkg::comp_t in_x,
  input  ots_pkg::comp_t in_y,
  input  ots_pkg::tri_t  in_c,
  output logic           out_vld,
  output ots_pkg::wvec_t out_p,
  output logic           out_nz
);
  import ots_pkg::*;

  localparam int PW = 2 * (CW + 1);
  localparam int SW = PW + 2;

  logic [2:0]              vld_r;
  logic signed [CW:0]      wt [3];
  logic signed [PW-1:0]    prod_r [3][3];
  logic signed [SW-1:0]    sum_r [3];
  wvec_t                   p;
  logic [SW-1:0]           rnd [3];
  wvec_t                   p_r;
  logic                    nz_r;

  // barycentric weights
  assign wt[0] = $signed({1'b0, ONE}) - $signed({1'b0, in_x}) - $signed({1'b0, in_y});
  assign wt[1] = $signed({1'b0, in_x});
  assign wt[2] = $signed({1'b0, in_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // round half up, non-positive clips to zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = $unsigned(sum_r[i]) + SW'(HALF);
      p[i]   = (sum_r[i] <= 0) ? '0 : rnd[i][FRAC+IW-1:FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 3; t++)
          prod_r[i][t] <= wt[t] * $signed({1'b0, in_c[t][i]});
        sum_r[i] <= SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]);
      end
      p_r  <= p;
      nz_r <= (p[0] != '0) || (p[1] != '0) || (p[2] != '0);
    end
  end

  assign out_vld = vld_r[2];
  assign out_p   = p_r;
  assign out_nz  = nz_r;

endmodule

`default_nettype wire

>>> tb/octant_triangle_to_sphere_core_tb.sv
// Self-checking testbench for the octant triangle-to-sphere core.
// Depends on ots_pkg and octant_triangle_to_sphere_core; predicts each vector in SV.
`default_nettype none

module octant_triangle_to_sphere_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ots_pkg::*;

  typedef longint unsigned u64;
  typedef struct { u64 c [3]; } vec3_t;
  typedef struct { logic [15:0] vx, vy, vz; } sphere_pt_t;

  localparam u64 UNIT     = u64'(1) << FRAC;
  localparam u64 HALF_U   = UNIT >> 1;
  localparam int LVL_CAP  = 12;
  localparam int LATENCY  = 40 + 37 * LVL_CAP;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_tri_x = '0;
  logic [15:0] in_tri_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_vec_x, out_vec_y, out_vec_z;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;

  sphere_pt_t  pending_vecs [$];
  logic [3:0]  level_reg = LVL_RST;
  bit          no_idle = 1'b0;
  int          mismatches = 0;
  int          rx_stall = 0;

  octant_triangle_to_sphere_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_tri_x(in_tri_x), .in_tri_y(in_tri_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vec_x(out_vec_x), .out_vec_y(out_vec_y), .out_vec_z(out_vec_z),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic u64 root_floor(u64 v);
    u64 r, b;
    r = 0;
    b = u64'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec3_t unit_len(vec3_t v);
    vec3_t o;
    u64 sq, len, q;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += v.c[i] * v.c[i];
    len = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0) begin
        q = ((v.c[i] << FRAC) + (len >> 1)) / len;
        if (q > UNIT) q = UNIT;
      end
      o.c[i] = q;
    end
    return o;
  endfunction

  function automatic vec3_t edge_mid(vec3_t a, vec3_t b);
    vec3_t s;
    for (int i = 0; i < 3; i++) s.c[i] = a.c[i] + b.c[i];
    return unit_len(s);
  endfunction

  function automatic u64 sat_unit(u64 v);
    return (v > UNIT) ? UNIT : v;
  endfunction

  function automatic sphere_pt_t project_point(logic [15:0] tx, logic [15:0] ty);
    vec3_t c1, c2, c3, m12, m31, p;
    u64 x, y;
    int lv;
    longint w1, s;
    sphere_pt_t r;
    c1.c = '{0, 0, UNIT};
    c2.c = '{UNIT, 0, 0};
    c3.c = '{0, UNIT, 0};
    x = sat_unit(u64'(tx));
    y = sat_unit(u64'(ty));
    lv = (level_reg > LVL_CAP) ? LVL_CAP : int'(level_reg);
    for (int l = 0; l < lv; l++) begin
      if (x < HALF_U) begin
        if (y < HALF_U) begin
          if (x + y < HALF_U) begin
            // corner at c1
            x = 2 * x;
            y = 2 * y;
            c2 = edge_mid(c1, c2);
            c3 = edge_mid(c3, c1);
          end else begin
            // flipped centre triangle
            m12 = edge_mid(c1, c2);
            m31 = edge_mid(c3, c1);
            x = UNIT - 2 * x;
            y = UNIT - 2 * y;
            c1 = edge_mid(c2, c3);
            c2 = m31;
            c3 = m12;
          end
        end else begin
          x = 2 * x;
          y = 2 * y - UNIT;
          c2 = edge_mid(c2, c3);
          c1 = edge_mid(c3, c1);
        end
      end else begin
        x = 2 * x - UNIT;
        y = 2 * y;
        c1 = edge_mid(c1, c2);
        c3 = edge_mid(c2, c3);
      end
      x = sat_unit(x);
      y = sat_unit(y);
    end
    // barycentric blend, negatives floored at zero
    for (int i = 0; i < 3; i++) begin
      w1 = longint'(UNIT) - longint'(x) - longint'(y);
      s = w1 * longint'(c1.c[i]) + longint'(x) * longint'(c2.c[i])
        + longint'(y) * longint'(c3.c[i]);
      p.c[i] = (s <= 0) ? 0 : ((u64'(s) + HALF_U) >> FRAC);
    end
    p = unit_len(p);
    r.vx = p.c[0][15:0];
    r.vy = p.c[1][15:0];
    r.vz = p.c[2][15:0];
    return r;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_stall = no_idle ? 0 : $urandom_range(0, 13);
      out_ready <= (rx_stall == 0);
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= (rx_stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each accepted vector with the oldest prediction
  always @(posedge clk) begin
    sphere_pt_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vecs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vector %0d %0d %0d", out_vec_x, out_vec_y, out_vec_z);
      end else begin
        e = pending_vecs.pop_front();
        if (e.vx !== out_vec_x || e.vy !== out_vec_y || e.vz !== out_vec_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vector mismatch: exp %0d %0d %0d got %0d %0d %0d",
                     e.vx, e.vy, e.vz, out_vec_x, out_vec_y, out_vec_z);
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_point(logic [15:0] tx, logic [15:0] ty);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tri_x <= tx;
    in_tri_y <= ty;
    do @(posedge clk); while (!in_ready);
    pending_vecs.push_back(project_point(tx, ty));
  endtask

  // drop valid straight after the last accepted item, then wait for every result
  task automatic drain_vectors();
    in_valid <= 1'b0;
    while (pending_vecs.size() != 0) @(posedge clk);
  endtask

  task automatic set_levels(logic [3:0] v);
    drain_vectors();
    repeat (LATENCY + 16) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    level_reg = v;
  endtask

  task automatic random_points(int n);
    logic [15:0] tx, ty;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin tx = 16'($urandom); ty = 16'($urandom); end
        1: begin
          tx = 16'($urandom_range(0, 32768));
          ty = 16'(32768 - tx + $urandom_range(0, 64));
        end
        default: begin
          tx = 16'($urandom_range(0, 32768));
          ty = 16'($urandom_range(0, 32768 - tx));
        end
      endcase
      send_point(tx, ty);
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_corners_and_edges();
    send_point(16'd0, 16'd0);
    send_point(16'd32768, 16'd0);
    send_point(16'd0, 16'd32768);
    send_point(16'd16384, 16'd16384);
    send_point(16'd16383, 16'd16384);
    send_point(16'd16383, 16'd0);
    send_point(16'd0, 16'd16383);
    send_point(16'd8191, 16'd8192);
    send_point(16'd32768, 16'd32768);
    send_point(16'd30000, 16'd30000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'hFFFF, 16'd0);
    send_point(16'd0, 16'hFFFF);
    send_point(16'd32769, 16'd1);
    send_point(16'd1, 16'd1);
    send_point(16'h5555, 16'h2AAA);
  endtask

  task automatic test_zero_levels();
    set_levels(4'd0);
    send_point(16'd0, 16'd0);
    send_point(16'd32768, 16'd32768);
    random_points(200);
  endtask

  task automatic test_max_levels();
    set_levels(4'd12);
    test_corners_and_edges();
    random_points(400);
  endtask

  task automatic test_levels_over_cap();
    set_levels(4'd15);
    send_point(16'hFFFF, 16'hFFFF);
    random_points(200);
  endtask

  task automatic test_back_to_back();
    set_levels(4'd5);
    no_idle = 1'b1;
    random_points(300);
    no_idle = 1'b0;
    random_points(150);
  endtask

  task automatic test_mixed_levels();
    set_levels(4'd1);
    random_points(150);
    set_levels(4'd13);
    random_points(100);
    for (int k = 0; k < 4; k++) begin
      set_levels(4'($urandom_range(0, 15)));
      random_points(100);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners_and_edges();
    random_points(100);
    test_zero_levels();
    test_max_levels();
    test_levels_over_cap();
    test_back_to_back();
    test_mixed_levels();
    drain_vectors();
    repeat (LATENCY + 16) @(posedge clk);
    if (mismatches == 0 && pending_vecs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
